FILE: design/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Shared types and constants for the event slot mailbox: request codes,
// slot record layout and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package esm_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int CODE_W  = 32;
  localparam int VALUE_W = 64;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 32;
  localparam int PEND_W  = 5;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    process;
    logic [ID_W-1:0]    thread;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic exec_send;
    logic exec_recv;
  } esm_cmd_t;

endpackage

FILE: design/esm_ram.sv
// ----------------------------------------------------------------------------
// esm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module esm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/esm_ctrl.sv
// ----------------------------------------------------------------------------
// esm_ctrl
// Mailbox controller: takes a request beat, issues the send or receive
// command to the datapath and presents the result in the following cycle.
// ----------------------------------------------------------------------------
module esm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              req_type,
  output logic              busy,
  output logic              done,
  output esm_pkg::esm_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t state;
  logic   take;

  assign take          = start && (state == ST_IDLE);
  assign cmd.exec_send = take && (req_type == esm_pkg::REQ_SEND);
  assign cmd.exec_recv = take && (req_type == esm_pkg::REQ_RECV);
  assign busy          = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_RESP;
            done  <= 1'b1;
          end else begin
            done  <= 1'b0;
          end
        end
        ST_RESP: begin
          // result beat is on the ports this cycle
          state <= ST_IDLE;
          done  <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/esm_dpath.sv
// ----------------------------------------------------------------------------
// esm_dpath
// Mailbox datapath: used marks, lowest-free and lowest-used search, slot
// memory, pending count, wrapping totals and the sticky ready flag.
// ----------------------------------------------------------------------------
module esm_dpath #(
  parameter int SLOTS = esm_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  esm_pkg::esm_cmd_t             cmd,
  input  logic [esm_pkg::CODE_W-1:0]    event_code,
  input  logic [esm_pkg::VALUE_W-1:0]   event_value,
  input  logic [esm_pkg::ID_W-1:0]      source_process,
  input  logic [esm_pkg::ID_W-1:0]      source_thread,
  output logic                          success,
  output logic [esm_pkg::CODE_W-1:0]    out_code,
  output logic [esm_pkg::VALUE_W-1:0]   out_value,
  output logic [esm_pkg::ID_W-1:0]      out_process,
  output logic [esm_pkg::ID_W-1:0]      out_thread,
  output logic [esm_pkg::PEND_W-1:0]    pending_now,
  output logic [esm_pkg::COUNT_W-1:0]   delivered_count,
  output logic [esm_pkg::COUNT_W-1:0]   received_count,
  output logic                          ready_flag
);

  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PendW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0]                 used;
  logic [PendW-1:0]                 pending;
  logic [esm_pkg::COUNT_W-1:0]      delivered;
  logic [esm_pkg::COUNT_W-1:0]      received;
  logic                             ready;
  logic                             rd_ok;

  logic                             free_found;
  logic [IdxW-1:0]                  free_idx;
  logic                             used_found;
  logic [IdxW-1:0]                  used_idx;
  logic                             store;
  logic                             take;
  esm_pkg::slot_t                   wr_slot;
  esm_pkg::slot_t                   rd_slot;
  logic [PendW+esm_pkg::PEND_W-1:0] pend_wide;

  // lowest free and lowest used slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    used_found = 1'b0;
    used_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      if (used[i]) begin
        used_found = 1'b1;
        used_idx   = IdxW'(i);
      end
    end
  end

  assign store = cmd.exec_send && (event_code != '0) && free_found;
  assign take  = cmd.exec_recv && used_found;

  assign wr_slot.code    = event_code;
  assign wr_slot.value   = event_value;
  assign wr_slot.process = source_process;
  assign wr_slot.thread  = source_thread;

  esm_ram #(
    .WIDTH (esm_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (store),
    .waddr (free_idx),
    .wdata (wr_slot),
    .re    (take),
    .raddr (used_idx),
    .rdata (rd_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      pending   <= '0;
      delivered <= '0;
      received  <= '0;
      ready     <= 1'b0;
      success   <= 1'b0;
      rd_ok     <= 1'b0;
    end else if (cmd.exec_send) begin
      rd_ok   <= 1'b0;
      success <= store;
      // a nonzero code raises the flag even when every slot is taken
      if (event_code != '0) begin
        ready <= 1'b1;
      end
      if (store) begin
        used[free_idx] <= 1'b1;
        pending        <= pending + 1'b1;
        delivered      <= delivered + 1'b1;
      end
    end else if (cmd.exec_recv) begin
      rd_ok   <= take;
      success <= take;
      if (take) begin
        used[used_idx] <= 1'b0;
        pending        <= pending - 1'b1;
        received       <= received + 1'b1;
      end
    end
  end

  assign pend_wide       = {{esm_pkg::PEND_W{1'b0}}, pending};
  assign pending_now     = pend_wide[esm_pkg::PEND_W-1:0];
  assign delivered_count = delivered;
  assign received_count  = received;
  assign ready_flag      = ready;

  // sends and empty receives report a zero event
  assign out_code    = rd_ok ? rd_slot.code    : '0;
  assign out_value   = rd_ok ? rd_slot.value   : '0;
  assign out_process = rd_ok ? rd_slot.process : '0;
  assign out_thread  = rd_ok ? rd_slot.thread  : '0;

endmodule

FILE: design/event_slot_mailbox_core.sv
// ----------------------------------------------------------------------------
// event_slot_mailbox_core
// Fixed-slot event mailbox: sends fill the lowest free slot, receives drain
// the lowest used slot.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// Each request returns exactly one result beat, marked by done for a single
// cycle, in the cycle right after the request was taken; the result cannot
// be held off, so capture it when done is high. The slot search and memory
// access happen in the accept cycle, and the slot memory's registered read
// delivers the result beat, during which busy is high, so no new request is
// taken until it is out. Status outputs keep their values between beats.
// ----------------------------------------------------------------------------
module event_slot_mailbox_core #(
  parameter int SLOTS = esm_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [esm_pkg::CODE_W-1:0]    event_code,
  input  logic [esm_pkg::VALUE_W-1:0]   event_value,
  input  logic [esm_pkg::ID_W-1:0]      source_process,
  input  logic [esm_pkg::ID_W-1:0]      source_thread,
  output logic                          done,
  output logic                          success,
  output logic [esm_pkg::CODE_W-1:0]    out_code,
  output logic [esm_pkg::VALUE_W-1:0]   out_value,
  output logic [esm_pkg::ID_W-1:0]      out_process,
  output logic [esm_pkg::ID_W-1:0]      out_thread,
  output logic [esm_pkg::PEND_W-1:0]    pending_now,
  output logic [esm_pkg::COUNT_W-1:0]   delivered_count,
  output logic [esm_pkg::COUNT_W-1:0]   received_count,
  output logic                          ready_flag
);

  esm_pkg::esm_cmd_t cmd;

  esm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  esm_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .event_code      (event_code),
    .event_value     (event_value),
    .source_process  (source_process),
    .source_thread   (source_thread),
    .success         (success),
    .out_code        (out_code),
    .out_value       (out_value),
    .out_process     (out_process),
    .out_thread      (out_thread),
    .pending_now     (pending_now),
    .delivered_count (delivered_count),
    .received_count  (received_count),
    .ready_flag      (ready_flag)
  );

endmodule

FILE: design/esm_checker.sv
// ----------------------------------------------------------------------------
// esm_checker
// Port-level checks for the event slot mailbox, bound to the top level.
// ----------------------------------------------------------------------------
module esm_checker #(
  parameter int SLOTS = esm_pkg::SLOTS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        success,
  input logic [esm_pkg::CODE_W-1:0]  out_code,
  input logic [esm_pkg::VALUE_W-1:0] out_value,
  input logic [esm_pkg::PEND_W-1:0]  pending_now,
  input logic [esm_pkg::COUNT_W-1:0] delivered_count
);

  // every request beat yields a result beat in the next cycle
  a_req_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done && busy))
    else $error("request beat without result beat");

  // no result beat without a request beat
  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result beat without request");

  // a failed request never returns event data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (out_code == '0 && out_value == '0))
    else $error("failed request returned event data");

  // counts move only on a result beat
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (!$stable(delivered_count) || !$stable(pending_now)) |-> done)
    else $error("status changed outside a result beat");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    (SLOTS >= 32) || (pending_now <= SLOTS))
    else $error("pending count above slot count");

endmodule

bind event_slot_mailbox_core esm_checker #(
  .SLOTS (SLOTS)
) u_esm_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .success         (success),
  .out_code        (out_code),
  .out_value       (out_value),
  .pending_now     (pending_now),
  .delivered_count (delivered_count)
);

FILE: tb/sv/tb_event_slot_mailbox_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_slot_mailbox_core
// Self-checking bench for the event slot mailbox. A queue of send and receive
// requests, directed corner cases first and then random segments that swing
// between filling and draining, feeds a clocked driver. A shadow mailbox
// predicts every result beat, and a clocked monitor compares each done beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_event_slot_mailbox_core;

  import esm_pkg::*;

  localparam int NSLOT       = SLOTS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int CALM_TAIL   = 80;

  typedef struct {
    logic               req;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    proc;
    logic [ID_W-1:0]    thread;
    bit                 drain_first;
  } mbox_req_t;

  typedef struct {
    logic               success;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    proc;
    logic [ID_W-1:0]    thread;
    logic [PEND_W-1:0]  pending_now;
    logic [COUNT_W-1:0] delivered;
    logic [COUNT_W-1:0] received;
    logic               ready;
  } mbox_resp_t;

  logic               clk;
  logic               rst            = 1'b1;
  logic               start          = 1'b0;
  logic               req_type       = REQ_RECV;
  logic [CODE_W-1:0]  event_code     = '0;
  logic [VALUE_W-1:0] event_value    = '0;
  logic [ID_W-1:0]    source_process = '0;
  logic [ID_W-1:0]    source_thread  = '0;
  logic               busy;
  logic               done;
  logic               success;
  logic [CODE_W-1:0]  out_code;
  logic [VALUE_W-1:0] out_value;
  logic [ID_W-1:0]    out_process;
  logic [ID_W-1:0]    out_thread;
  logic [PEND_W-1:0]  pending_now;
  logic [COUNT_W-1:0] delivered_count;
  logic [COUNT_W-1:0] received_count;
  logic               ready_flag;

  event_slot_mailbox_core #(.SLOTS(NSLOT)) dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .event_code      (event_code),
    .event_value     (event_value),
    .source_process  (source_process),
    .source_thread   (source_thread),
    .done            (done),
    .success         (success),
    .out_code        (out_code),
    .out_value       (out_value),
    .out_process     (out_process),
    .out_thread      (out_thread),
    .pending_now     (pending_now),
    .delivered_count (delivered_count),
    .received_count  (received_count),
    .ready_flag      (ready_flag)
  );

  // Shadow mailbox
  bit                 box_used   [NSLOT];
  logic [CODE_W-1:0]  box_code   [NSLOT];
  logic [VALUE_W-1:0] box_value  [NSLOT];
  logic [ID_W-1:0]    box_proc   [NSLOT];
  logic [ID_W-1:0]    box_thread [NSLOT];
  int                 box_fill;
  logic [COUNT_W-1:0] stored_total;
  logic [COUNT_W-1:0] taken_total;
  logic               ready_seen;

  mbox_req_t  request_q[$];
  mbox_resp_t awaited_results[$];
  mbox_req_t  on_ports;
  int         total_requests;
  int         accepted;
  int         gap_left;
  int         stall_cycles;
  int         errors;
  bit         took;

  // Coverage tallies for the closing summary
  int n_stored, n_full, n_zero, n_taken, n_empty, peak_fill;

  function automatic mbox_resp_t serve_request(mbox_req_t r);
    mbox_resp_t e;
    int         hit;
    e   = '{default: '0};
    hit = -1;
    if (r.req == REQ_SEND) begin
      if (r.code == '0) begin
        n_zero++;
      end else begin
        ready_seen = 1'b1;
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!box_used[i]) hit = i;
        if (box_fill < NSLOT && hit >= 0) begin
          box_used[hit]   = 1'b1;
          box_code[hit]   = r.code;
          box_value[hit]  = r.value;
          box_proc[hit]   = r.proc;
          box_thread[hit] = r.thread;
          box_fill++;
          stored_total++;
          e.success = 1'b1;
          n_stored++;
        end else begin
          n_full++;
        end
      end
    end else begin
      for (int i = NSLOT - 1; i >= 0; i--)
        if (box_used[i]) hit = i;
      if (box_fill != 0 && hit >= 0) begin
        e.code    = box_code[hit];
        e.value   = box_value[hit];
        e.proc    = box_proc[hit];
        e.thread  = box_thread[hit];
        // free the slot and wipe its contents
        box_used[hit]   = 1'b0;
        box_code[hit]   = '0;
        box_value[hit]  = '0;
        box_proc[hit]   = '0;
        box_thread[hit] = '0;
        box_fill--;
        taken_total++;
        e.success = 1'b1;
        n_taken++;
      end else begin
        n_empty++;
      end
    end
    if (box_fill > peak_fill) peak_fill = box_fill;
    e.pending_now = box_fill[PEND_W-1:0];
    e.delivered   = stored_total;
    e.received    = taken_total;
    e.ready       = ready_seen;
    return e;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic mbox_req_t make_send(logic [CODE_W-1:0] code, logic [VALUE_W-1:0] value,
                                          logic [ID_W-1:0] proc, logic [ID_W-1:0] thread);
    mbox_req_t r;
    r = '{req: REQ_SEND, code: code, value: value, proc: proc, thread: thread,
          drain_first: 1'b0};
    return r;
  endfunction

  function automatic mbox_req_t make_recv();
    mbox_req_t r;
    // receive ignores the payload fields, so fill them with junk
    r = '{req: REQ_RECV, code: $urandom, value: {$urandom, $urandom}, proc: $urandom,
          thread: $urandom, drain_first: 1'b0};
    return r;
  endfunction

  function automatic mbox_req_t random_send();
    mbox_req_t r;
    r = make_send($urandom, {$urandom, $urandom}, $urandom, $urandom);
    case ($urandom_range(0, 15))
      0: r.code = '0;
      1: r.code = '1;
      2: r.code = 32'd1;
      default: ;
    endcase
    case ($urandom_range(0, 11))
      0: r.value = '0;
      1: r.value = '1;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      r.proc   = '0;
      r.thread = '0;
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stimulus list and end of run
  initial begin
    int        seg_len;
    int        send_pct;
    int        n_rand;
    mbox_req_t r;

    for (int i = 0; i < NSLOT; i++) begin
      box_used[i]   = 1'b0;
      box_code[i]   = '0;
      box_value[i]  = '0;
      box_proc[i]   = '0;
      box_thread[i] = '0;
    end
    box_fill     = 0;
    stored_total = '0;
    taken_total  = '0;
    ready_seen   = 1'b0;
    errors       = 0;
    accepted     = 0;
    gap_left     = 0;
    stall_cycles = 0;
    n_stored = 0; n_full = 0; n_zero = 0; n_taken = 0; n_empty = 0; peak_fill = 0;

    // Directed: empty receive, zero code before any valid send, field extremes,
    // lowest-slot reuse, fill to full, refused sends on a full mailbox, drain one.
    request_q.push_back(make_recv());
    request_q.push_back(make_send('0, '1, '1, '1));
    request_q.push_back(make_send('1, '1, '1, '1));
    request_q.push_back(make_send(32'd1, '0, '0, '0));
    request_q.push_back(make_recv());
    for (int i = 0; i < NSLOT - 1; i++)
      request_q.push_back(make_send(32'h100 + i, {$urandom, $urandom}, $urandom, $urandom));
    request_q.push_back(make_send(32'hdead_beef, '1, 32'd7, 32'd9));
    request_q.push_back(make_send('0, '0, '0, '0));
    request_q.push_back(make_recv());

    // Random segments, each biased toward filling or draining
    n_rand = 0;
    while (n_rand < 650) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: send_pct = 20;
        1: send_pct = 50;
        2: send_pct = 80;
        default: send_pct = 95;
      endcase
      for (int k = 0; k < seg_len && n_rand < 650; k++) begin
        r = ($urandom_range(0, 99) < send_pct) ? random_send() : make_recv();
        r.drain_first = (n_rand == 0) || ($urandom_range(0, 79) == 0);
        request_q.push_back(r);
        n_rand++;
      end
    end
    total_requests = request_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || awaited_results.size() != 0 || start)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d requests: %0d stored, %0d refused full, %0d zero code,",
             accepted, n_stored, n_full, n_zero);
    $display("  %0d events taken, %0d empty receives, peak occupancy %0d of %0d slots.",
             n_taken, n_empty, peak_fill, NSLOT);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Driver: hold each request until it is taken, idle in random bursts
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        awaited_results.push_back(serve_request(on_ports));
        accepted++;
      end
      if (took || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (accepted < total_requests - CALM_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
          start <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain_first && awaited_results.size() != 0)) begin
          on_ports = request_q.pop_front();
          req_type       <= on_ports.req;
          event_code     <= on_ports.code;
          event_value    <= on_ports.value;
          source_process <= on_ports.proc;
          source_thread  <= on_ports.thread;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest prediction
  always @(posedge clk) begin
    mbox_resp_t e;
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with no request outstanding", $time);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        check_field("success", e.success, success);
        check_field("out_code", e.code, out_code);
        check_field("out_value", e.value, out_value);
        check_field("out_process", e.proc, out_process);
        check_field("out_thread", e.thread, out_thread);
        check_field("pending_now", e.pending_now, pending_now);
        check_field("delivered_count", e.delivered, delivered_count);
        check_field("received_count", e.received, received_count);
        check_field("ready_flag", e.ready, ready_flag);
      end
    end
  end

  // Watchdog: too long without a taken request or a result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no activity for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
design/esm_pkg.sv
design/esm_ram.sv
design/esm_ctrl.sv
design/esm_dpath.sv
design/event_slot_mailbox_core.sv
design/esm_checker.sv
tb/sv/tb_event_slot_mailbox_core.sv
